// ----- src/punrank_pkg.sv -----
`timescale 1ns / 1ps

package punrank_pkg;

    localparam int RANK_W          = 64;
    localparam int SYM_W           = 4;
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int RESULT_CAP      = 16;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int BITCNT_W        = $clog2(RANK_W);

    localparam logic [CFG_W-1:0] SYMBOL_COUNT_RST = 5'd4;
    localparam logic [CFG_W-1:0] ARR_LENGTH_RST   = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_COUNT       = 1'b0,
        CFG_ARRANGEMENT_LENGTH = 1'b1
    } t_cfg_idx;

    // divider control: load takes a fresh dividend, start runs one division
    typedef struct packed {
        logic load;
        logic start;
    } t_div_ctrl;

endpackage

// ----- src/punrank_div.sv -----
`timescale 1ns / 1ps

module punrank_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  punrank_pkg::t_div_ctrl           i_ctrl,
    input  logic [punrank_pkg::RANK_W-1:0]   i_dividend,
    input  logic [punrank_pkg::CFG_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [punrank_pkg::SYM_W-1:0]    o_rem
);
    import punrank_pkg::*;

    localparam logic [BITCNT_W-1:0] CNT_LAST = BITCNT_W'(RANK_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [BITCNT_W-1:0] r_cnt;
    logic [RANK_W-1:0]   r_quo;
    logic [SYM_W-1:0]    r_rem;
    logic [CFG_W-1:0]    r_div;

    logic [CFG_W-1:0]    w_trial;
    logic [CFG_W-1:0]    w_diff;
    logic                w_ge;

    // restoring division, one quotient bit per cycle; quotient replaces the dividend
    always_comb begin
        w_trial = {r_rem, r_quo[RANK_W-1]};
        w_ge    = (w_trial >= r_div);
        w_diff  = w_trial - r_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                if (i_ctrl.load) begin
                    r_quo <= i_dividend;
                end
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[SYM_W-1:0] : w_trial[SYM_W-1:0];
                r_quo <= {r_quo[RANK_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/permutation_unrank_top.sv -----
`timescale 1ns / 1ps

// Permutation unranking: a 64-bit rank on the input channel selects an
// arrangement of L symbols drawn from 0..n-1 (n = symbol_count capped at
// CAP, L = arrangement_length, or n when that register is zero).
// Configuration: write beats on the cfg channel, index 0 symbol_count,
// index 1 arrangement_length; always ready, write only while idle.
// Each input beat yields L output beats in pick order, last position first,
// with o_last set on the final one. A bad length (L > n, or n = 0) yields one
// beat with o_length_error and o_last set, position and symbol zero.
// Each pick runs the bit-serial division of the rank by the list size (one
// bit per cycle); the registered done flag then moves control to its emit
// step, which emits and shrinks the list. A bad length skips the division
// and goes straight to the emit step. One rank is worked on at a time:
// o_in_ready is high only once the previous rank's last pick has gone into
// the output register. A stalled receiver holds the output register and
// the block waits in its emit step until the beat is taken. Reset clears
// all control state and sets symbol_count to 4 and arrangement_length to
// 0; no output beat is pending.
module permutation_unrank_top #(
    parameter int MAX_SYMBOLS = punrank_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [punrank_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [punrank_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [punrank_pkg::RANK_W-1:0]      i_rank,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [punrank_pkg::SYM_W-1:0]       o_position,
    output logic [punrank_pkg::SYM_W-1:0]       o_symbol,
    output logic                                o_length_error,
    output logic                                o_last
);
    import punrank_pkg::*;

    localparam int CAP   = (MAX_SYMBOLS < RESULT_CAP) ? MAX_SYMBOLS : RESULT_CAP;
    localparam int IDX_W = $clog2(CAP);
    localparam logic [CFG_W-1:0] CAP_N = CFG_W'(CAP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_symbol_count;
    logic [CFG_W-1:0] r_arr_length;
    logic [CFG_W-1:0] r_len;
    logic [CFG_W-1:0] r_size;
    logic [CFG_W-1:0] r_picks;
    logic             r_err;
    logic [SYM_W-1:0] r_list [CAP];

    logic             r_out_valid;
    logic [SYM_W-1:0] r_position;
    logic [SYM_W-1:0] r_symbol;
    logic             r_length_error;
    logic             r_last;

    logic [SYM_W-1:0] n_list [CAP];
    logic [CFG_W-1:0] w_n_eff;
    logic [CFG_W-1:0] w_len;
    logic             w_bad;
    logic             w_accept;
    logic             w_out_free;
    logic             w_emit;
    logic             w_final;
    logic [IDX_W-1:0] w_sel;
    logic [SYM_W-1:0] w_rem;
    logic             w_div_done;
    t_div_ctrl        w_div_ctrl;
    logic [CFG_W-1:0] w_divisor;

    always_comb begin
        w_n_eff    = (r_symbol_count > CAP_N) ? CAP_N : r_symbol_count;
        w_len      = (r_arr_length == '0) ? w_n_eff : r_arr_length;
        w_bad      = (w_n_eff == '0) || (w_len > w_n_eff);
        w_accept   = i_in_valid && (r_state == S_IDLE);
        w_out_free = !r_out_valid || i_out_ready;
        w_emit     = (r_state == S_EMIT) && w_out_free;
        w_final    = (r_picks + 1'b1 == r_len);
        w_sel      = w_rem[IDX_W-1:0];
    end

    // removing the picked entry closes the gap from above
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_list[i] = r_list[i];
        end
        for (int i = 0; i < CAP - 1; i++) begin
            if (IDX_W'(i) >= w_sel) begin
                n_list[i] = r_list[i + 1];
            end
        end
    end

    always_comb begin
        w_div_ctrl.load  = w_accept && !w_bad;
        w_div_ctrl.start = (w_accept && !w_bad) || (w_emit && !r_err && !w_final);
        w_divisor        = (r_state == S_IDLE) ? w_n_eff : r_size - 1'b1;
    end

    punrank_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (i_rank),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_symbol_count <= SYMBOL_COUNT_RST;
            r_arr_length   <= ARR_LENGTH_RST;
            r_out_valid    <= 1'b0;
            r_err          <= 1'b0;
            r_picks        <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SYMBOL_COUNT) begin
                    r_symbol_count <= i_cfg_data;
                end else if (i_cfg_index == CFG_ARRANGEMENT_LENGTH) begin
                    r_arr_length <= i_cfg_data;
                end
            end

            // a new beat taking the register's place keeps valid high
            if (r_out_valid && i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_err   <= w_bad;
                        r_len   <= w_len;
                        r_size  <= w_n_eff;
                        r_picks <= '0;
                        for (int i = 0; i < CAP; i++) begin
                            r_list[i] <= SYM_W'(w_n_eff - 1'b1 - CFG_W'(i));
                        end
                        r_state <= w_bad ? S_EMIT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_err) begin
                            r_position     <= '0;
                            r_symbol       <= '0;
                            r_length_error <= 1'b1;
                            r_last         <= 1'b1;
                            r_state        <= S_IDLE;
                        end else begin
                            r_position     <= SYM_W'(r_len - 1'b1 - r_picks);
                            r_symbol       <= r_list[w_sel];
                            r_length_error <= 1'b0;
                            r_last         <= w_final;
                            r_list         <= n_list;
                            r_size         <= r_size - 1'b1;
                            r_picks        <= r_picks + 1'b1;
                            r_state        <= w_final ? S_IDLE : S_DIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_position     = r_position;
    assign o_symbol       = r_symbol;
    assign o_length_error = r_length_error;
    assign o_last         = r_last;

endmodule

// ----- sim/punrank_checker.sv -----
`timescale 1ns / 1ps

module punrank_checker #(
    parameter int MAX_SYMBOLS = punrank_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [punrank_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [punrank_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [punrank_pkg::RANK_W-1:0]    i_rank,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [punrank_pkg::SYM_W-1:0]     i_position,
    input  logic [punrank_pkg::SYM_W-1:0]     i_symbol,
    input  logic                              i_length_error,
    input  logic                              i_last,
    output int                                o_fail_count,
    output int                                o_pending
);
    import punrank_pkg::*;

    localparam int POOL_CAP = (MAX_SYMBOLS > RESULT_CAP) ? RESULT_CAP : MAX_SYMBOLS;

    typedef struct packed {
        logic [SYM_W-1:0] position;
        logic [SYM_W-1:0] symbol;
        logic             length_error;
        logic             last;
    } t_pick;

    t_pick            expected_picks[$];
    logic [CFG_W-1:0] symbol_count_q = SYMBOL_COUNT_RST;
    logic [CFG_W-1:0] arr_len_q      = ARR_LENGTH_RST;
    int               fault_count    = 0;
    int               beat_no        = 0;

    task automatic report_fault(input string msg);
        fault_count++;
        $display("[chk] %0t ns, out beat %0d: %s", $time, beat_no, msg);
    endtask

    function automatic void queue_pick(input t_pick p);
        expected_picks = {expected_picks, p};
    endfunction

    // unrank one rank into the picks it selects, last position first
    function automatic void predict_arrangement(input logic [RANK_W-1:0] rank);
        int unsigned      n;
        int unsigned      len;
        int unsigned      size;
        int unsigned      sel;
        int unsigned      i;
        int unsigned      pick;
        logic [SYM_W-1:0] pool [RESULT_CAP];
        logic [RANK_W-1:0] rem;
        t_pick            p;

        n = symbol_count_q;
        if (n > POOL_CAP)
            n = POOL_CAP;
        len = (arr_len_q != 0) ? arr_len_q : n;

        if (n == 0 || len > n) begin
            p.position     = '0;
            p.symbol       = '0;
            p.length_error = 1'b1;
            p.last         = 1'b1;
            queue_pick(p);
            return;
        end

        for (i = 0; i < n; i++)
            pool[i] = SYM_W'(n - 1 - i);
        size = n;
        rem  = rank;

        for (pick = 0; pick < len; pick++) begin
            sel = 32'(rem % 64'(size));
            rem = rem / 64'(size);
            if (sel >= RESULT_CAP)
                sel = RESULT_CAP - 1;
            p.symbol = pool[sel];
            for (i = sel; i + 1 < size; i++)
                pool[i] = pool[i + 1];
            size--;
            p.position     = SYM_W'(len - 1 - pick);
            p.length_error = 1'b0;
            p.last         = (pick + 1 == len);
            queue_pick(p);
        end
    endfunction

    task automatic check_beat();
        t_pick want;

        beat_no++;
        if (expected_picks.size() == 0) begin
            report_fault($sformatf("beat with nothing expected (pos %0d sym %0d err %0b last %0b)",
                                   i_position, i_symbol, i_length_error, i_last));
            return;
        end
        want = expected_picks.pop_front();
        if (i_position !== want.position)
            report_fault($sformatf("position %0d, want %0d", i_position, want.position));
        if (i_symbol !== want.symbol)
            report_fault($sformatf("symbol %0d, want %0d", i_symbol, want.symbol));
        if (i_length_error !== want.length_error)
            report_fault($sformatf("length_error %0b, want %0b", i_length_error,
                                   want.length_error));
        if (i_last !== want.last)
            report_fault($sformatf("last %0b, want %0b", i_last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            symbol_count_q = SYMBOL_COUNT_RST;
            arr_len_q      = ARR_LENGTH_RST;
            expected_picks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SYMBOL_COUNT:       symbol_count_q = i_cfg_data;
                    CFG_ARRANGEMENT_LENGTH: arr_len_q      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                check_beat();
            if (i_in_valid && i_in_ready)
                predict_arrangement(i_rank);
        end
        o_fail_count <= fault_count;
        o_pending    <= expected_picks.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import punrank_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int OUT_HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_BEAT = 400;
    localparam int TAIL_CYCLES     = 200;
    localparam int RANDOM_RANKS    = 250;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [RANK_W-1:0]    i_rank;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SYM_W-1:0]     o_position;
    logic [SYM_W-1:0]     o_symbol;
    logic                 o_length_error;
    logic                 o_last;

    int fail_count;
    int exp_pending;
    int idle_cycles = 0;
    int in_burst    = 0;
    int out_burst   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    permutation_unrank_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rank         (i_rank),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_position     (o_position),
        .o_symbol       (o_symbol),
        .o_length_error (o_length_error),
        .o_last         (o_last)
    );

    punrank_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rank         (i_rank),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_position     (o_position),
        .i_symbol       (o_symbol),
        .i_length_error (o_length_error),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (exp_pending)
    );

    // gap before the next beat; now and then a run of back-to-back beats
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [RANK_W-1:0] random_rank();
        logic [RANK_W-1:0] r;

        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: r = r >> $urandom_range(1, 63);
            1: r = RANK_W'($urandom_range(0, 5000));
            2: r = '1;
            3: r = RANK_W'(1) << $urandom_range(0, 63);
            default: ;
        endcase
        return r;
    endfunction

    // valid is left high on return so a back-to-back beat needs no extra edge
    task automatic send_rank(input logic [RANK_W-1:0] r);
        int gap;

        gap = draw_gap(in_burst);
        if (gap > 0) begin
            if (i_in_valid)
                i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rank     <= r;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic drain_block();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        do @(posedge i_clk); while (exp_pending != 0 || !o_in_ready);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] n_sym, input logic [CFG_W-1:0] k_len);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SYMBOL_COUNT;
        i_cfg_data  <= n_sym;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_index <= CFG_ARRANGEMENT_LENGTH;
        i_cfg_data  <= k_len;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("permutation_unrank_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver; one long hold-off while the sender is offering fills the block up
    initial begin
        int gap;
        int beats;
        bit held;

        beats = 0;
        held  = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        gap = draw_gap(out_burst);
        repeat (gap) @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            beats++;
            if (!held && beats >= HOLD_AFTER_BEAT && i_in_valid) begin
                held = 1'b1;
                gap  = OUT_HOLD_CYCLES;
            end else begin
                gap = draw_gap(out_burst);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int sc;
        int kl;
        int sent;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SYMBOL_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_rank      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: four symbols, full permutation; 24 wraps to the first
        send_rank(64'd0);
        send_rank(64'd23);
        send_rank(64'd24);
        send_rank('1);

        // full alphabet: 16! - 1 is the last arrangement, 16! wraps
        set_config(5'd16, 5'd0);
        send_rank(64'd0);
        send_rank(64'd20922789887999);
        send_rank(64'd20922789888000);
        send_rank('1);

        set_config(5'd1, 5'd1);
        send_rank(64'd0);
        send_rank('1);

        // length beyond alphabet
        set_config(5'd5, 5'd6);
        send_rank(64'd1);
        set_config(5'd16, 5'd17);
        send_rank(64'd2);

        // empty alphabet, with and without a length
        set_config(5'd0, 5'd0);
        send_rank(64'd5);
        set_config(5'd0, 5'd3);
        send_rank(64'd7);

        // alphabet above capacity saturates
        set_config(5'd31, 5'd3);
        send_rank('1);
        send_rank(64'd12345);
        set_config(5'd31, 5'd31);
        send_rank(64'd9);

        set_config(5'd16, 5'd16);
        send_rank(64'h8000_0000_0000_0000);
        set_config(5'd16, 5'd1);
        send_rank(64'd15);
        send_rank(64'd16);
        set_config(5'd2, 5'd0);
        send_rank(64'd0);
        send_rank(64'd1);

        sent = 0;
        while (sent < RANDOM_RANKS) begin
            case ($urandom_range(0, 9))
                0: begin
                    sc = $urandom_range(17, 31);
                    kl = $urandom_range(0, 16);
                end
                1: begin
                    sc = $urandom_range(0, 16);
                    kl = $urandom_range(sc + 1, 31);
                end
                2: begin
                    sc = $urandom_range(1, 16);
                    kl = 0;
                end
                default: begin
                    sc = $urandom_range(1, 16);
                    kl = $urandom_range(0, sc);
                end
            endcase
            set_config(CFG_W'(sc), CFG_W'(kl));
            repeat ($urandom_range(5, 20)) begin
                send_rank(random_rank());
                sent++;
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && exp_pending == 0) begin
            $display("permutation_unrank_top: match");
        end else begin
            $display("permutation_unrank_top: mismatch");
        end
        $finish;
    end

endmodule
